[rtl/lhm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the latency histogram monitor.
// No dependencies; every other file of the block imports this package.
package lhm_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned TOTAL_W     = 64;
  localparam int unsigned BIN_FIELD_W = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

  localparam logic [DATA_W-1:0] RANGE_LOW_RST  = 32'd0;
  localparam logic [DATA_W-1:0] RANGE_HIGH_RST = 32'd20000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_READ,
    ST_UPD,
    ST_OUT
  } lhm_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } lhm_div_sts_t;

endpackage

[rtl/lhm_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the latency histogram monitor: request and result.
// Depends on lhm_pkg for field widths.
interface lhm_req_if;
  import lhm_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [DATA_W-1:0]   sample_us;
  logic [BIN_FIELD_W-1:0] read_bin;

  modport source (output valid, action, sample_us, read_bin, input ready);
  modport sink   (input valid, action, sample_us, read_bin, output ready);
endinterface

interface lhm_rsp_if;
  import lhm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TOTAL_W-1:0]     total_us;
  logic [DATA_W-1:0]      sample_count;
  logic [DATA_W-1:0]      largest_us;
  logic [DATA_W-1:0]      smallest_us;
  logic [BIN_FIELD_W-1:0] bin_number;
  logic [DATA_W-1:0]      bin_total;

  modport source (output valid, total_us, sample_count, largest_us, smallest_us,
                  bin_number, bin_total, input ready);
  modport sink   (input valid, total_us, sample_count, largest_us, smallest_us,
                  bin_number, bin_total, output ready);
endinterface

[rtl/lhm_div.sv]
`timescale 1ns / 1ps
// Bit-serial bin divider: (diff * BIN_COUNT) / span, one quotient bit per cycle.
// Depends on lhm_pkg. Requires diff < span, so the quotient fits in the bin index.
module lhm_div #(
  parameter int unsigned BIN_COUNT = 200
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lhm_pkg::DATA_W-1:0]    diff_i,
  input  logic [lhm_pkg::DATA_W-1:0]    span_i,
  output lhm_pkg::lhm_div_sts_t         sts_o,
  output logic [$clog2(BIN_COUNT)-1:0]  quot_o
);
  import lhm_pkg::*;

  localparam int unsigned BIN_W = $clog2(BIN_COUNT);
  localparam int unsigned PW    = DATA_W + BIN_W;
  localparam int unsigned SW    = $clog2(BIN_W + 1);

  logic [DATA_W-1:0] rem_q, rem_d;
  logic [BIN_W-1:0]  lq_q, lq_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [PW-1:0]     prod;
  logic [DATA_W:0]   rem_ext;
  logic [DATA_W:0]   rem_sub;
  logic              ge;

  // dividend: upper bits seed the remainder, lower bits shift in and are
  // replaced by quotient bits
  assign prod    = PW'(diff_i) * PW'(BIN_COUNT);
  assign rem_ext = {rem_q, lq_q[BIN_W-1]};
  assign rem_sub = rem_ext - {1'b0, span_i};
  assign ge      = (rem_ext >= {1'b0, span_i});

  always_comb begin
    rem_d  = rem_q;
    lq_d   = lq_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = prod[PW-1:BIN_W];
      lq_d   = prod[BIN_W-1:0];
      cnt_d  = SW'(BIN_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DATA_W-1:0] : rem_ext[DATA_W-1:0];
      lq_d  = BIN_W'({lq_q, ge});
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lq_q  <= lq_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = lq_q;

endmodule

[rtl/latency_histogram_monitor.sv]
`timescale 1ns / 1ps
// Latency histogram monitor: running total, count, min, max and a BIN_COUNT-bin
// histogram over [range_low, range_high). Depends on lhm_pkg, lhm_if, lhm_div.
//
// One request is handled at a time. A recorded sample inside the range goes
// through PREP, DIV_GO, DIV_WAIT (the serial divider, one bin-index bit per
// cycle), READ, UPD and OUT before the next possible transfer; reads and
// samples outside the range skip the divider and go through PREP, the bin
// memory read and update (READ, UPD) and OUT. A finished result sits in the
// output register while the next request is already accepted. After reset
// the bin memory is cleared one entry per cycle, every entry in turn, with no
// request accepted meanwhile; register writes are taken at any time but must
// only be issued while the block is idle.
module latency_histogram_monitor #(
  parameter int unsigned BIN_COUNT = 200
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lhm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lhm_pkg::DATA_W-1:0]      cfg_data_i,
  lhm_req_if.sink                         req_i,
  lhm_rsp_if.source                       rsp_o
);
  import lhm_pkg::*;

  localparam int unsigned BIN_W = $clog2(BIN_COUNT);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

  lhm_state_e state_q, state_d;

  logic [DATA_W-1:0]  low_q, high_q;
  logic [TOTAL_W-1:0] total_q;
  logic [DATA_W-1:0]  sample_cnt_q, max_q, min_q;
  logic [BIN_W-1:0]   clr_q;
  logic               out_valid_q;

  logic                   act_q;
  logic [DATA_W-1:0]      smp_q;
  logic [BIN_FIELD_W-1:0] rb_q;
  logic [DATA_W-1:0]      diff_q, span_q;
  logic [BIN_W-1:0]       bin_q;
  logic [DATA_W-1:0]      rd_q, btot_q;

  logic [DATA_W-1:0] bin_mem [BIN_COUNT];

  logic              in_ready, accept, record;
  logic              div_start, mem_re, mem_we, out_load, out_free;
  logic              empty_rng, below, above, direct;
  logic [BIN_W-1:0]  direct_bin, rb_bin, quot_bin, mem_waddr;
  logic [DATA_W-1:0] upd_val, mem_wdata;

  lhm_div_sts_t      div_sts;
  logic [BIN_W-1:0]  div_quot;

  lhm_div #(.BIN_COUNT(BIN_COUNT)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (diff_q),
    .span_i  (span_q),
    .sts_o   (div_sts),
    .quot_o  (div_quot)
  );

  // ---- bin selection ----
  assign empty_rng = (high_q <= low_q);
  assign below     = (smp_q < low_q);
  assign above     = (smp_q >= high_q);
  assign record    = (act_q == ACT_RECORD);
  assign direct    = !record || empty_rng || below || above;
  assign rb_bin    = (32'(rb_q) >= 32'(BIN_COUNT)) ? LAST_BIN : BIN_W'(rb_q);
  assign quot_bin  = (32'(div_quot) >= 32'(BIN_COUNT)) ? LAST_BIN : div_quot;

  always_comb begin
    if (!record) begin
      direct_bin = rb_bin;
    end else if (empty_rng || above) begin
      direct_bin = LAST_BIN;
    end else begin
      direct_bin = '0;
    end
  end

  assign upd_val  = (record && (rd_q != '1)) ? rd_q + DATA_W'(1) : rd_q;
  assign out_free = !out_valid_q || rsp_o.ready;

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_q == LAST_BIN) state_d = ST_IDLE;
      ST_IDLE:     if (req_i.valid) state_d = ST_PREP;
      ST_PREP:     state_d = direct ? ST_READ : ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_sts.done) state_d = ST_READ;
      ST_READ:     state_d = ST_UPD;
      ST_UPD:      state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    mem_waddr = bin_q;
    mem_wdata = upd_val;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE:   in_ready  = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      ST_READ:   mem_re    = 1'b1;
      ST_UPD:    mem_we    = record;
      ST_OUT:    out_load  = out_free;
      default: ;
    endcase
  end

  assign req_i.ready = in_ready;
  assign accept      = req_i.valid && in_ready;

  // ---- control and statistics ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      low_q        <= RANGE_LOW_RST;
      high_q       <= RANGE_HIGH_RST;
      total_q      <= '0;
      sample_cnt_q <= '0;
      max_q        <= '0;
      min_q        <= '1;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + BIN_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RANGE_LOW:  low_q  <= cfg_data_i;
          CFG_RANGE_HIGH: high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && (req_i.action == ACT_RECORD)) begin
        total_q <= total_q + TOTAL_W'(req_i.sample_us);
        if (sample_cnt_q != '1) begin
          sample_cnt_q <= sample_cnt_q + DATA_W'(1);
        end
        if (req_i.sample_us > max_q) begin
          max_q <= req_i.sample_us;
        end
        if (req_i.sample_us < min_q) begin
          min_q <= req_i.sample_us;
        end
      end
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= req_i.action;
      smp_q <= req_i.sample_us;
      rb_q  <= req_i.read_bin;
    end
    if (state_q == ST_PREP) begin
      diff_q <= smp_q - low_q;
      span_q <= high_q - low_q;
      bin_q  <= direct_bin;
    end
    if ((state_q == ST_DIV_WAIT) && div_sts.done) begin
      bin_q <= quot_bin;
    end
    if (state_q == ST_UPD) begin
      btot_q <= upd_val;
    end
    if (out_load) begin
      rsp_o.total_us     <= total_q;
      rsp_o.sample_count <= sample_cnt_q;
      rsp_o.largest_us   <= max_q;
      rsp_o.smallest_us  <= min_q;
      rsp_o.bin_number   <= BIN_FIELD_W'(bin_q);
      rsp_o.bin_total    <= btot_q;
    end
  end

  assign rsp_o.valid = out_valid_q;

  // ---- bin memory ----
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= bin_mem[bin_q];
    end
  end

  // ---- assertions ----
  a_div_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_WAIT |-> div_sts.busy || div_sts.done)
    else $error("divider idle while waiting for quotient");

  a_bin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> bin_q <= LAST_BIN)
    else $error("bin index out of range at memory read");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_CLEAR |=> sample_cnt_q >= $past(sample_cnt_q))
    else $error("sample count decreased");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_cnt_q != '0 |-> min_q <= max_q)
    else $error("smallest sample exceeds largest");

endmodule
